// ===== sv/dgskl_pkg.sv =====
package dgskl_pkg;

  // Accumulator and result width, signed, with FRAC_BITS fraction bits.
  localparam int ACC_W  = 48;
  // A quotient keeps this many bits; anything above saturates.
  localparam int QUOT_W = 47;

  typedef struct packed {
    logic done;
    logic over;
  } div_stat_t;

endpackage

// ===== sv/dgskl_divider.sv =====
module dgskl_divider #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [DEN_W-1:0]              den_i,
  output dgskl_pkg::div_stat_t          stat_o,
  output logic [dgskl_pkg::QUOT_W-1:0]  quot_o
);
  import dgskl_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             over_q, over_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0] quo_q, quo_d;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Restoring division, one numerator bit per cycle, MSB first. The divisor
  // must stay put until done.
  always_comb begin
    trial  = {rem_q, num_q[NUM_W-1]};
    diff   = trial - {1'b0, den_i};
    ge     = (trial >= {1'b0, den_i});
    busy_d = busy_q;
    done_d = 1'b0;
    over_d = over_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      over_d = 1'b0;
      cnt_d  = CW'(NUM_W - 1);
      num_d  = num_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], 1'b0};
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[QUOT_W-2:0], ge};
      // A quotient bit at or above the kept width means overflow.
      if (ge && (int'(cnt_q) >= QUOT_W)) begin
        over_d = 1'b1;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    over_q <= over_d;
    cnt_q  <= cnt_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.over = over_q;
  assign quot_o      = quo_q;

endmodule

// ===== sv/diag_gaussian_symmetric_kl.sv =====
// An accepted word runs through the bit-serial squarer and the shared bit-serial
// divider, run twice per word (NUM_W = max(2*VALUE_WIDTH, VALUE_WIDTH+FRAC_BITS) + 1);
// a word with a zero variance skips both. A new word is taken only once the last one
// is finished, and a last word waits while an earlier result is still held.
// Reset (asynchronous, active low) clears the sum, the flags and the handshakes.
module diag_gaussian_symmetric_kl #(
  parameter int VALUE_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] mean_left_i,
  input  logic [VALUE_WIDTH-1:0]        variance_left_i,
  input  logic signed [VALUE_WIDTH-1:0] mean_right_i,
  input  logic [VALUE_WIDTH-1:0]        variance_right_i,
  input  logic                          last_dim_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [dgskl_pkg::ACC_W-1:0] divergence_o,
  output logic                          zero_variance_o,
  output logic                          saturated_o
);
  import dgskl_pkg::*;

  localparam int W      = VALUE_WIDTH;
  localparam int PROD_W = 2 * W;
  localparam int NUM_W  = ((PROD_W > W + FRAC_BITS) ? PROD_W : W + FRAC_BITS) + 1;
  localparam int MCW    = $clog2(W);
  localparam int SUM_W  = ACC_W + 2;
  localparam logic [SUM_W-1:0] TWO = SUM_W'(2) << FRAC_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_STA  = 3'd2;
  localparam logic [2:0] ST_DIVA = 3'd3;
  localparam logic [2:0] ST_STB  = 3'd4;
  localparam logic [2:0] ST_DIVB = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic              zero_q, zero_d;
  logic              sat_q, sat_d;

  logic [W-1:0]      vl_q, vl_d;
  logic [W-1:0]      vr_q, vr_d;
  logic [W-1:0]      ad_q, ad_d;
  logic [W-1:0]      mq_q, mq_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [MCW-1:0]    mcnt_q, mcnt_d;
  logic [QUOT_W-1:0] qa_q, qa_d;
  logic [QUOT_W-1:0] qb_q, qb_d;
  logic              qsat_q, qsat_d;
  logic              last_q, last_d;
  logic              skip_q, skip_d;
  logic [ACC_W-1:0]  div_out_q, div_out_d;
  logic              zero_out_q, zero_out_d;
  logic              sat_out_q, sat_out_d;

  logic [W:0]        diff;
  logic [W:0]        diff_abs;
  logic              in_fire;
  logic              div_start;
  logic              sel_b;
  logic [W-1:0]      num_base;
  logic [NUM_W-1:0]  div_num;
  logic [W-1:0]      div_den;
  div_stat_t         div_stat;
  logic [QUOT_W-1:0] div_quot;
  logic [QUOT_W-1:0] quot_sat;
  logic signed [SUM_W-1:0] sum;
  logic              sum_hi, sum_lo;
  logic [ACC_W-1:0]  acc_new;
  logic              sat_new;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Both quotients share one divider: the second swaps the two variances.
  assign sel_b     = (state_q == ST_STB) || (state_q == ST_DIVB);
  assign div_start = (state_q == ST_STA) || (state_q == ST_STB);
  assign num_base  = sel_b ? vr_q : vl_q;
  assign div_num   = NUM_W'({num_base, {FRAC_BITS{1'b0}}}) + NUM_W'(prod_q);
  assign div_den   = sel_b ? vl_q : vr_q;
  assign quot_sat  = div_stat.over ? {QUOT_W{1'b1}} : div_quot;

  dgskl_divider #(
    .NUM_W (NUM_W),
    .DEN_W (W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  always_comb begin
    diff     = {mean_left_i[W-1], mean_left_i} - {mean_right_i[W-1], mean_right_i};
    diff_abs = diff[W] ? (~diff + 1'b1) : diff;

    sum = $signed({{2{acc_q[ACC_W-1]}}, acc_q}) + $signed(SUM_W'(qa_q))
        + $signed(SUM_W'(qb_q)) - $signed(TWO);
    sum_hi = !sum[SUM_W-1] && (sum[SUM_W-2:ACC_W-1] != '0);
    sum_lo = sum[SUM_W-1] && (sum[SUM_W-2:ACC_W-1] != '1);
    if (skip_q) begin
      acc_new = acc_q;
    end else if (sum_hi) begin
      acc_new = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (sum_lo) begin
      acc_new = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_new = sum[ACC_W-1:0];
    end
    sat_new = sat_q || (!skip_q && (qsat_q || sum_hi || sum_lo));

    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    acc_d       = acc_q;
    zero_d      = zero_q;
    sat_d       = sat_q;
    vl_d        = vl_q;
    vr_d        = vr_q;
    ad_d        = ad_q;
    mq_d        = mq_q;
    prod_d      = prod_q;
    mcnt_d      = mcnt_q;
    qa_d        = qa_q;
    qb_d        = qb_q;
    qsat_d      = qsat_q;
    last_d      = last_q;
    skip_d      = skip_q;
    div_out_d   = div_out_q;
    zero_out_d  = zero_out_q;
    sat_out_d   = sat_out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          vl_d   = variance_left_i;
          vr_d   = variance_right_i;
          ad_d   = diff_abs[W-1:0];
          mq_d   = diff_abs[W-1:0];
          prod_d = '0;
          mcnt_d = MCW'(W - 1);
          qsat_d = 1'b0;
          last_d = last_dim_i;
          skip_d = (variance_left_i == '0) || (variance_right_i == '0);
          state_d = skip_d ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        // Shift-add square of |d|, one multiplier bit per cycle, MSB first.
        prod_d = {prod_q[PROD_W-2:0], 1'b0} + (mq_q[W-1] ? PROD_W'(ad_q) : '0);
        mq_d   = {mq_q[W-2:0], 1'b0};
        if (mcnt_q == '0) begin
          state_d = ST_STA;
        end else begin
          mcnt_d = mcnt_q - 1'b1;
        end
      end
      ST_STA: begin
        state_d = ST_DIVA;
      end
      ST_DIVA: begin
        if (div_stat.done) begin
          qa_d    = quot_sat;
          qsat_d  = qsat_q || div_stat.over;
          state_d = ST_STB;
        end
      end
      ST_STB: begin
        state_d = ST_DIVB;
      end
      ST_DIVB: begin
        if (div_stat.done) begin
          qb_d    = quot_sat;
          qsat_d  = qsat_q || div_stat.over;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          acc_d   = acc_new;
          zero_d  = zero_q || skip_q;
          sat_d   = sat_new;
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          // Halve by arithmetic shift, then start a fresh pair.
          div_out_d   = {acc_new[ACC_W-1], acc_new[ACC_W-1:1]};
          zero_out_d  = zero_q || skip_q;
          sat_out_d   = sat_new;
          out_valid_d = 1'b1;
          acc_d       = '0;
          zero_d      = 1'b0;
          sat_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      zero_q      <= 1'b0;
      sat_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      zero_q      <= zero_d;
      sat_q       <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vl_q       <= vl_d;
    vr_q       <= vr_d;
    ad_q       <= ad_d;
    mq_q       <= mq_d;
    prod_q     <= prod_d;
    mcnt_q     <= mcnt_d;
    qa_q       <= qa_d;
    qb_q       <= qb_d;
    qsat_q     <= qsat_d;
    last_q     <= last_d;
    skip_q     <= skip_d;
    div_out_q  <= div_out_d;
    zero_out_q <= zero_out_d;
    sat_out_q  <= sat_out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign divergence_o    = div_out_q;
  assign zero_variance_o = zero_out_q;
  assign saturated_o     = sat_out_q;

endmodule

// ===== sv/dgskl_checker.sv =====
module dgskl_checker #(
  parameter int VALUE_WIDTH = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic signed [VALUE_WIDTH-1:0] mean_left_i,
  input logic [VALUE_WIDTH-1:0]        variance_left_i,
  input logic signed [VALUE_WIDTH-1:0] mean_right_i,
  input logic [VALUE_WIDTH-1:0]        variance_right_i,
  input logic                          last_dim_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [dgskl_pkg::ACC_W-1:0] divergence_o,
  input logic                          zero_variance_o,
  input logic                          saturated_o
);

  // One word at a time: taking a word closes the input side.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready right after a word was taken");

  // A new result only comes out of a finished word.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while the block was idle");

  // Finishing a word frees the input side at once.
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("input not ready when a result was posted");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(divergence_o)
      && $stable(zero_variance_o) && $stable(saturated_o))
    else $error("stalled result changed");

endmodule

bind diag_gaussian_symmetric_kl dgskl_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (.*);

// ===== dv/tb_diag_gaussian_symmetric_kl.sv =====
`timescale 1ns / 100ps

module tb_diag_gaussian_symmetric_kl;
  import dgskl_pkg::*;

  localparam int VW = 24;
  localparam int FB = 16;
  localparam longint SUM_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint SUM_MIN = -(longint'(1) <<< (ACC_W - 1));
  localparam logic [63:0] QUOT_LIMIT = (64'd1 << QUOT_W) - 1;

  localparam logic signed [VW-1:0] MEAN_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] MEAN_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] VAR_MAX = {VW{1'b1}};
  localparam logic [VW-1:0] VAR_ONE = VW'(1) << FB;

  typedef struct {
    logic signed [ACC_W-1:0] divergence;
    logic                    zero_variance;
    logic                    saturated;
  } kl_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [VW-1:0] mean_left_i;
  logic [VW-1:0] variance_left_i;
  logic signed [VW-1:0] mean_right_i;
  logic [VW-1:0] variance_right_i;
  logic last_dim_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [ACC_W-1:0] divergence_o;
  logic zero_variance_o;
  logic saturated_o;

  // Predicted pair state and the divergences still owed by the block.
  longint kl_sum;
  bit kl_zero_seen;
  bit kl_sat_seen;
  kl_result_t divergence_q[$];

  int mismatches = 0;
  int items_sent = 0;
  bit idle_en = 1'b1;

  diag_gaussian_symmetric_kl #(
    .VALUE_WIDTH(VW),
    .FRAC_BITS  (FB)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mean_left_i     (mean_left_i),
    .variance_left_i (variance_left_i),
    .mean_right_i    (mean_right_i),
    .variance_right_i(variance_right_i),
    .last_dim_i      (last_dim_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .divergence_o    (divergence_o),
    .zero_variance_o (zero_variance_o),
    .saturated_o     (saturated_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(18_000_000);
    $display("tb_diag_gaussian_symmetric_kl failed");
    $finish;
  end

  function automatic logic [63:0] clipped_quotient(input logic [63:0] num,
                                                   input logic [VW-1:0] divisor,
                                                   output bit over);
    logic [63:0] q;
    q = num / {{(64-VW){1'b0}}, divisor};
    over = (q > QUOT_LIMIT);
    return over ? QUOT_LIMIT : q;
  endfunction

  task automatic predict_dim(input logic signed [VW-1:0] ml, input logic [VW-1:0] vl,
                             input logic signed [VW-1:0] mr, input logic [VW-1:0] vr,
                             input logic last);
    longint diff;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] qa;
    logic [63:0] qb;
    bit over_a;
    bit over_b;
    longint acc;
    kl_result_t res;
    if (vl == 0 || vr == 0) begin
      kl_zero_seen = 1'b1;
    end else begin
      diff = longint'(ml) - longint'(mr);
      mag = (diff < 0) ? -diff : diff;
      sq = mag * mag;
      qa = clipped_quotient(({{(64-VW){1'b0}}, vl} << FB) + sq, vr, over_a);
      qb = clipped_quotient(({{(64-VW){1'b0}}, vr} << FB) + sq, vl, over_b);
      if (over_a || over_b) kl_sat_seen = 1'b1;
      acc = kl_sum + longint'(qa) + longint'(qb) - (longint'(2) <<< FB);
      if (acc > SUM_MAX) begin
        acc = SUM_MAX;
        kl_sat_seen = 1'b1;
      end else if (acc < SUM_MIN) begin
        acc = SUM_MIN;
        kl_sat_seen = 1'b1;
      end
      kl_sum = acc;
    end
    if (last) begin
      // Halving is an arithmetic shift, so odd negative sums round down.
      res.divergence = ACC_W'(kl_sum >>> 1);
      res.zero_variance = kl_zero_seen;
      res.saturated = kl_sat_seen;
      divergence_q.push_back(res);
      kl_sum = 0;
      kl_zero_seen = 1'b0;
      kl_sat_seen = 1'b0;
    end
  endtask

  // Called and returns at a falling edge; valid is dropped after each word.
  task automatic send_dim(input logic signed [VW-1:0] ml, input logic [VW-1:0] vl,
                          input logic signed [VW-1:0] mr, input logic [VW-1:0] vr,
                          input logic last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    mean_left_i = ml;
    variance_left_i = vl;
    mean_right_i = mr;
    variance_right_i = vr;
    last_dim_i = last;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_dim(ml, vl, mr, vr, last);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_random_pair();
    int len;
    int kind;
    logic signed [VW-1:0] ml;
    logic signed [VW-1:0] mr;
    logic [VW-1:0] vl;
    logic [VW-1:0] vr;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        ml = VW'(int'($urandom_range(0, 1048575)) - 524288);
        mr = VW'(int'($urandom_range(0, 1048575)) - 524288);
        vl = VW'($urandom_range(4096, 1048576));
        vr = VW'($urandom_range(4096, 1048576));
      end else if (kind < 75) begin
        ml = VW'($urandom());
        mr = VW'($urandom());
        vl = VW'($urandom());
        vr = VW'($urandom());
      end else if (kind < 85) begin
        // Nearly equal distributions, where truncation can pull the term below zero.
        ml = VW'($urandom());
        mr = VW'(ml + VW'($urandom_range(0, 2)) - 1);
        vl = VW'($urandom_range(60000, 70000));
        vr = VW'(vl + VW'($urandom_range(0, 8)) - 4);
      end else if (kind < 93) begin
        ml = VW'($urandom());
        mr = VW'($urandom());
        vl = VW'($urandom_range(1, 255));
        vr = VW'($urandom_range(1, 255));
      end else begin
        ml = VW'($urandom());
        mr = VW'($urandom());
        vl = ($urandom_range(0, 1) == 0) ? '0 : VW'($urandom());
        vr = (vl != 0 || $urandom_range(0, 1) == 0) ? '0 : VW'($urandom());
      end
      send_dim(ml, vl, mr, vr, i == len - 1);
    end
  endtask

  task automatic test_basic_pairs();
    send_dim(0, VAR_ONE, 0, VAR_ONE, 1'b1);
    send_dim(24'sh001234, 24'd65537, 24'sh001234, 24'd65539, 1'b1);
    send_dim(24'sh010000, VAR_ONE, 24'sh000000, 24'h020000, 1'b0);
    send_dim(-24'sh008000, 24'h008000, 24'sh004000, 24'h030000, 1'b0);
    send_dim(24'sh100000, 24'h001000, 24'sh0FF000, 24'h001000, 1'b1);
  endtask

  task automatic test_extremes();
    send_dim(MEAN_MAX, 24'd1, MEAN_MIN, 24'd1, 1'b1);
    send_dim(MEAN_MIN, VAR_MAX, MEAN_MAX, VAR_MAX, 1'b1);
    send_dim(0, VAR_MAX, 0, 24'd1, 1'b1);
    send_dim(MEAN_MAX, 24'd1, MEAN_MAX, VAR_MAX, 1'b1);
    send_dim(MEAN_MIN, VAR_ONE, MEAN_MIN, VAR_ONE, 1'b1);
  endtask

  task automatic test_zero_variance();
    send_dim(24'sh020000, 24'd0, 24'sh010000, VAR_ONE, 1'b0);
    send_dim(24'sh010000, VAR_ONE, 0, VAR_ONE, 1'b1);
    send_dim(MEAN_MAX, VAR_ONE, MEAN_MIN, 24'd0, 1'b1);
    send_dim(MEAN_MIN, 24'd0, MEAN_MAX, 24'd0, 1'b1);
  endtask

  task automatic test_saturation();
    // Several saturated quotients in a row drive the sum into its upper clamp.
    send_dim(MEAN_MAX, 24'd1, MEAN_MIN, 24'd2, 1'b0);
    send_dim(MEAN_MIN, 24'd3, MEAN_MAX, 24'd1, 1'b0);
    send_dim(0, VAR_ONE, 0, VAR_ONE, 1'b1);
    // The flags must not leak into the next pair.
    send_dim(0, VAR_ONE, 0, VAR_ONE, 1'b1);
  endtask

  task automatic test_drain_pause();
    send_random_pair();
    while (divergence_q.size() != 0) @(negedge clk_i);
    send_random_pair();
    send_random_pair();
  endtask

  task automatic test_random_traffic(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_random_pair();
  endtask

  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 9) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  initial begin : result_checker
    kl_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (divergence_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected word: divergence %0d zero %0b sat %0b",
                     divergence_o, zero_variance_o, saturated_o);
          end
        end else begin
          want = divergence_q.pop_front();
          if (divergence_o !== want.divergence || zero_variance_o !== want.zero_variance ||
              saturated_o !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: divergence exp %0d got %0d, zero exp %0b got %0b, %s",
                       want.divergence, divergence_o, want.zero_variance, zero_variance_o,
                       $sformatf("sat exp %0b got %0b", want.saturated, saturated_o));
            end
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mean_left_i = '0;
    variance_left_i = '0;
    mean_right_i = '0;
    variance_right_i = '0;
    last_dim_i = 1'b0;
    kl_sum = 0;
    kl_zero_seen = 1'b0;
    kl_sat_seen = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_pairs();
    test_extremes();
    test_zero_variance();
    test_saturation();
    test_drain_pause();
    test_random_traffic(1150);
    idle_en = 1'b0;
    test_random_traffic(300);

    while (divergence_q.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    if (mismatches == 0 && divergence_q.size() == 0) begin
      $display("tb_diag_gaussian_symmetric_kl passed");
    end else begin
      $display("tb_diag_gaussian_symmetric_kl failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/dgskl_pkg.sv
sv/dgskl_divider.sv
sv/diag_gaussian_symmetric_kl.sv
sv/dgskl_checker.sv
dv/tb_diag_gaussian_symmetric_kl.sv
